@@ rtl/core/drs_pkg.sv @@
// ----------------------------------------------------------------------------
// drs_pkg
// Types and constants shared by the disk request scheduler modules.
// ----------------------------------------------------------------------------
package drs_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_POLICY    = 3'd0,
		CFG_DIR_UP    = 3'd1,
		CFG_HEAD_INIT = 3'd2,
		CFG_SPT       = 3'd3,
		CFG_SEEK      = 3'd4,
		CFG_ROT       = 3'd5,
		CFG_XFER      = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		POL_FIFO  = 2'd0,
		POL_SSTF  = 2'd1,
		POL_LOOK  = 2'd2,
		POL_CLOOK = 2'd3
	} policy_t;

	typedef enum logic [2:0] {
		F_LOAD,
		F_WAIT,
		F_RD,
		F_RDW,
		F_DIV,
		F_SCAN,
		F_PICK,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_WAITQ,
		B_RD,
		B_DIST,
		B_MUL,
		B_SEEK,
		B_DIV,
		B_ROT,
		B_OUT
	} back_state_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned NUM_W  = 7;

	// per-batch settings handed from front to back
	typedef struct packed {
		logic [NUM_W-1:0] n;
		logic [31:0]      head_init;
		logic [31:0]      period;
		logic [15:0]      seek_ticks;
		logic [15:0]      rot_ticks;
		logic [15:0]      xfer_ticks;
		logic             dropped;
	} batch_t;

	// entry write into the back store
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic [31:0]      addr;
		logic [15:0]      count;
		logic [31:0]      cyl;
		logic [15:0]      sec;
	} entry_wr_t;

	typedef struct packed {
		logic             start;
		logic             q_push;
		logic [IDX_W-1:0] q_idx;
	} front_ctl_t;

	typedef struct packed {
		logic idle;
		logic q_full;
	} back_status_t;

endpackage

@@ rtl/core/drs_ram.sv @@
// ----------------------------------------------------------------------------
// drs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module drs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/drs_div.sv @@
// ----------------------------------------------------------------------------
// drs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drs_div #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/core/drs_front.sv @@
// ----------------------------------------------------------------------------
// drs_front
// Collects a batch, splits addresses into cylinder and sector, and picks the
// service order, pushing request indexes into the back end queue.
// ----------------------------------------------------------------------------
module drs_front #(
	parameter int unsigned MAX_REQUESTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [31:0]           block_address,
	input  logic [15:0]           sector_count,
	input  logic                  batch_end,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  drs_pkg::back_status_t bst,
	output drs_pkg::batch_t       batch,
	output drs_pkg::front_ctl_t   ctl,
	output drs_pkg::entry_wr_t    ewr
);

	localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
	localparam int unsigned IW = MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1;

	// configuration registers
	drs_pkg::policy_t policy_q;
	logic             dir_up_q;
	logic [31:0]      head_init_q;
	logic [15:0]      spt_q;
	logic [15:0]      seek_ticks_q;
	logic [15:0]      rot_ticks_q;
	logic [15:0]      xfer_ticks_q;

	drs_pkg::front_state_t state_q, state_d;
	drs_pkg::batch_t       batch_q;
	drs_pkg::policy_t      pol_q;
	logic                  dir_q;
	logic [15:0]           spt_b_q;
	logic [CW-1:0]         cnt_q;
	logic                  dropped_q;
	logic [CW-1:0]         i_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         n_last;
	logic [MAX_REQUESTS-1:0] served_q;
	logic [31:0]           cur_q;

	// scan pipeline and best candidate
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic [IW-1:0] best_i_q;
	logic [31:0]   best_c_q;
	logic [31:0]   best_d_q;
	logic          best_g_q;

	logic          acc;
	logic          store_ok;
	logic [15:0]   cnt_eff;
	logic [15:0]   spt_eff;
	logic [47:0]   ra_rdata;
	logic [31:0]   cyl_rdata;
	logic          div_start;
	logic          div_done;
	logic [31:0]   div_quo;
	logic [15:0]   div_rem;
	logic [31:0]   d;
	logic          g;
	logic          asc;
	logic          better;
	logic          last_pick;

	assign acc      = push && !full;
	assign store_ok = cnt_q < CW'(MAX_REQUESTS);
	assign cnt_eff  = (sector_count == 16'd0) ? 16'd1 : sector_count;
	assign spt_eff  = (spt_q == 16'd0) ? 16'd1 : spt_q;
	assign n_last   = cnt_q - CW'(1);
	assign last_pick = (k_q == n_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= drs_pkg::POL_FIFO;
			dir_up_q     <= 1'b1;
			head_init_q  <= 32'd0;
			spt_q        <= 16'd100;
			seek_ticks_q <= 16'd1;
			rot_ticks_q  <= 16'd1;
			xfer_ticks_q <= 16'd1;
		end else if (cfg_we) begin
			case (drs_pkg::cfg_idx_t'(cfg_index))
				drs_pkg::CFG_POLICY:    policy_q     <= drs_pkg::policy_t'(cfg_data[1:0]);
				drs_pkg::CFG_DIR_UP:    dir_up_q     <= cfg_data[0];
				drs_pkg::CFG_HEAD_INIT: head_init_q  <= cfg_data;
				drs_pkg::CFG_SPT:       spt_q        <= cfg_data[15:0];
				drs_pkg::CFG_SEEK:      seek_ticks_q <= cfg_data[15:0];
				drs_pkg::CFG_ROT:       rot_ticks_q  <= cfg_data[15:0];
				drs_pkg::CFG_XFER:      xfer_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// request store, address and sector count
	drs_ram #(.WIDTH(48), .DEPTH(MAX_REQUESTS)) u_req_ram (
		.clk   (clk),
		.we    (acc && store_ok),
		.waddr (cnt_q[IW-1:0]),
		.wdata ({block_address, cnt_eff}),
		.raddr (i_q[IW-1:0]),
		.rdata (ra_rdata)
	);

	// cylinder store used by the order scan
	drs_ram #(.WIDTH(32), .DEPTH(MAX_REQUESTS)) u_cyl_ram (
		.clk   (clk),
		.we    (ewr.we),
		.waddr (i_q[IW-1:0]),
		.wdata (div_quo),
		.raddr (i_q[IW-1:0]),
		.rdata (cyl_rdata)
	);

	drs_div #(.NW(32), .DW(16)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ra_rdata[47:16]),
		.den    (spt_b_q),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// candidate ranking
	always_comb begin
		d   = (cyl_rdata >= cur_q) ? cyl_rdata - cur_q : cur_q - cyl_rdata;
		g   = dir_q ? (cyl_rdata < batch_q.head_init) : (cyl_rdata > batch_q.head_init);
		asc = dir_q ? (!g || pol_q == drs_pkg::POL_CLOOK)
		            : (g && pol_q != drs_pkg::POL_CLOOK);
		if (!found_q) begin
			better = 1'b1;
		end else if (pol_q == drs_pkg::POL_SSTF) begin
			better = (d < best_d_q) || (d == best_d_q && cyl_rdata < best_c_q);
		end else if (g != best_g_q) begin
			better = !g;
		end else begin
			// descending order lets the later arrival win a tie
			better = asc ? (cyl_rdata < best_c_q) : (cyl_rdata >= best_c_q);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			drs_pkg::F_LOAD: begin
				if (acc && batch_end) state_d = drs_pkg::F_WAIT;
			end
			drs_pkg::F_WAIT: begin
				if (bst.idle) state_d = drs_pkg::F_RD;
			end
			drs_pkg::F_RD: state_d = drs_pkg::F_RDW;
			drs_pkg::F_RDW: state_d = drs_pkg::F_DIV;
			drs_pkg::F_DIV: begin
				if (div_done) begin
					if (i_q != n_last) begin
						state_d = drs_pkg::F_RD;
					end else if (pol_q == drs_pkg::POL_FIFO) begin
						state_d = drs_pkg::F_PUSH;
					end else begin
						state_d = drs_pkg::F_SCAN;
					end
				end
			end
			drs_pkg::F_SCAN: begin
				if (i_q == n_last) state_d = drs_pkg::F_PICK;
			end
			drs_pkg::F_PICK: state_d = drs_pkg::F_PUSH;
			drs_pkg::F_PUSH: begin
				if (!bst.q_full) begin
					if (last_pick) begin
						state_d = drs_pkg::F_LOAD;
					end else if (pol_q != drs_pkg::POL_FIFO) begin
						state_d = drs_pkg::F_SCAN;
					end
				end
			end
			default: state_d = drs_pkg::F_LOAD;
		endcase
	end

	always_comb begin
		full       = (state_q != drs_pkg::F_LOAD);
		div_start  = (state_q == drs_pkg::F_RDW);
		ctl.start  = (state_q == drs_pkg::F_WAIT) && bst.idle;
		ctl.q_push = (state_q == drs_pkg::F_PUSH) && !bst.q_full;
		ctl.q_idx  = (pol_q == drs_pkg::POL_FIFO) ? drs_pkg::IDX_W'(k_q)
		                                          : drs_pkg::IDX_W'(best_i_q);
		ewr.we     = (state_q == drs_pkg::F_DIV) && div_done;
		ewr.idx    = drs_pkg::IDX_W'(i_q);
		ewr.addr   = ra_rdata[47:16];
		ewr.count  = ra_rdata[15:0];
		ewr.cyl    = div_quo;
		ewr.sec    = div_rem;
	end

	assign batch = batch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= drs_pkg::F_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			i_q       <= '0;
			k_q       <= '0;
			served_q  <= '0;
			valid_s1  <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == drs_pkg::F_SCAN);
			case (state_q)
				drs_pkg::F_LOAD: begin
					if (acc) begin
						if (store_ok) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
					end
					i_q <= '0;
				end
				drs_pkg::F_WAIT: begin
					k_q      <= '0;
					served_q <= '0;
				end
				drs_pkg::F_DIV: begin
					if (div_done) begin
						i_q     <= (i_q == n_last) ? '0 : i_q + CW'(1);
						found_q <= 1'b0;
					end
				end
				drs_pkg::F_SCAN: begin
					i_q <= (i_q == n_last) ? '0 : i_q + CW'(1);
				end
				drs_pkg::F_PUSH: begin
					if (!bst.q_full) begin
						k_q     <= k_q + CW'(1);
						found_q <= 1'b0;
						if (pol_q != drs_pkg::POL_FIFO) begin
							served_q[best_i_q] <= 1'b1;
						end
						if (last_pick) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
			if (valid_s1 && !served_q[idx_s1] && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= i_q[IW-1:0];
		if (state_q == drs_pkg::F_LOAD && acc && batch_end) begin
			batch_q.n          <= drs_pkg::NUM_W'(cnt_q + CW'(store_ok));
			batch_q.head_init  <= head_init_q;
			batch_q.period     <= spt_eff * rot_ticks_q;
			batch_q.seek_ticks <= seek_ticks_q;
			batch_q.rot_ticks  <= rot_ticks_q;
			batch_q.xfer_ticks <= xfer_ticks_q;
			batch_q.dropped    <= dropped_q | !store_ok;
			pol_q              <= policy_q;
			dir_q              <= dir_up_q;
			spt_b_q            <= spt_eff;
		end
		if (state_q == drs_pkg::F_WAIT) begin
			cur_q <= batch_q.head_init;
		end else if (state_q == drs_pkg::F_PUSH && !bst.q_full) begin
			cur_q <= best_c_q;
		end
		if (valid_s1 && !served_q[idx_s1] && better) begin
			best_i_q <= idx_s1;
			best_c_q <= cyl_rdata;
			best_d_q <= d;
			best_g_q <= g;
		end
	end

endmodule

@@ rtl/core/drs_back.sv @@
// ----------------------------------------------------------------------------
// drs_back
// Serves requests in queue order and computes seek, rotation, transfer and
// completion times, holding each result in an output register.
// ----------------------------------------------------------------------------
module drs_back #(
	parameter int unsigned MAX_REQUESTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  drs_pkg::batch_t       batch,
	input  drs_pkg::front_ctl_t   ctl,
	input  drs_pkg::entry_wr_t    ewr,
	output drs_pkg::back_status_t bst,
	output logic                  empty,
	input  logic                  pop,
	output logic [5:0]            arrival_index,
	output logic [31:0]           served_address,
	output logic [31:0]           cylinder,
	output logic [15:0]           sector,
	output logic [47:0]           seek_time,
	output logic [31:0]           rotation_wait,
	output logic [31:0]           transfer_time,
	output logic [55:0]           done_time,
	output logic [37:0]           seek_distance_total,
	output logic                  overflow,
	output logic                  last_result
);

	localparam int unsigned IW  = MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1;
	localparam int unsigned QAW = $clog2(drs_pkg::QDEPTH);
	localparam int unsigned QCW = $clog2(drs_pkg::QDEPTH + 1);

	drs_pkg::back_state_t state_q, state_d;
	drs_pkg::batch_t      bp_q;

	// index queue from the front end
	logic [drs_pkg::IDX_W-1:0] q_mem_q [drs_pkg::QDEPTH];
	logic [QAW-1:0]            q_wp_q;
	logic [QAW-1:0]            q_rp_q;
	logic [QCW-1:0]            q_cnt_q;
	logic                      q_full;
	logic                      q_pop;

	logic [drs_pkg::IDX_W-1:0] cur_idx_q;
	logic [drs_pkg::NUM_W-1:0] k_q;
	logic [31:0]               head_q;
	logic [55:0]               clk_q;
	logic [37:0]               dsum_q;
	logic [31:0]               e_addr_q;
	logic [15:0]               e_cnt_q;
	logic [31:0]               e_cyl_q;
	logic [15:0]               e_sec_q;
	logic [31:0]               dist_q;
	logic [47:0]               seek_q;
	logic [31:0]               tgt_q;
	logic [31:0]               xfer_q;
	logic [31:0]               rot_q;
	logic                      out_valid_q;

	logic [95:0]               rb_rdata;
	logic [55:0]               clk_seek;
	logic                      div_start;
	logic                      div_done;
	logic [55:0]               div_quo;
	logic [31:0]               div_rem;
	logic [32:0]               rot_t;
	logic [31:0]               rot_calc;
	logic                      last;
	logic                      load;

	assign q_full   = (q_cnt_q == QCW'(drs_pkg::QDEPTH));
	assign q_pop    = (state_q == drs_pkg::B_WAITQ) && (q_cnt_q != '0);
	assign bst.idle = (state_q == drs_pkg::B_IDLE);
	assign bst.q_full = q_full;
	assign last     = (k_q == bp_q.n - drs_pkg::NUM_W'(1));
	assign load     = (state_q == drs_pkg::B_OUT) && !out_valid_q;
	assign clk_seek = clk_q + 56'(seek_q);
	assign div_start = (state_q == drs_pkg::B_SEEK) && (bp_q.period != 32'd0);
	assign empty    = !out_valid_q;

	drs_ram #(.WIDTH(96), .DEPTH(MAX_REQUESTS)) u_entry_ram (
		.clk   (clk),
		.we    (ewr.we),
		.waddr (ewr.idx[IW-1:0]),
		.wdata ({ewr.addr, ewr.count, ewr.cyl, ewr.sec}),
		.raddr (cur_idx_q[IW-1:0]),
		.rdata (rb_rdata)
	);

	// clock modulo rotation period
	drs_div #(.NW(56), .DW(32)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (clk_seek),
		.den    (bp_q.period),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// target is below the period, so one correction is enough
	always_comb begin
		rot_t    = {1'b0, tgt_q} + {1'b0, bp_q.period} - {1'b0, div_rem};
		rot_calc = (rot_t >= {1'b0, bp_q.period}) ? 32'(rot_t - {1'b0, bp_q.period})
		                                          : rot_t[31:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			drs_pkg::B_IDLE: begin
				if (ctl.start) state_d = drs_pkg::B_WAITQ;
			end
			drs_pkg::B_WAITQ: begin
				if (q_cnt_q != '0) state_d = drs_pkg::B_RD;
			end
			drs_pkg::B_RD:   state_d = drs_pkg::B_DIST;
			drs_pkg::B_DIST: state_d = drs_pkg::B_MUL;
			drs_pkg::B_MUL:  state_d = drs_pkg::B_SEEK;
			drs_pkg::B_SEEK: begin
				state_d = (bp_q.period != 32'd0) ? drs_pkg::B_DIV : drs_pkg::B_ROT;
			end
			drs_pkg::B_DIV: begin
				if (div_done) state_d = drs_pkg::B_ROT;
			end
			drs_pkg::B_ROT: state_d = drs_pkg::B_OUT;
			drs_pkg::B_OUT: begin
				if (!out_valid_q) state_d = last ? drs_pkg::B_IDLE : drs_pkg::B_WAITQ;
			end
			default: state_d = drs_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drs_pkg::B_IDLE;
			q_wp_q      <= '0;
			q_rp_q      <= '0;
			q_cnt_q     <= '0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.q_push) q_wp_q <= q_wp_q + QAW'(1);
			if (q_pop) q_rp_q <= q_rp_q + QAW'(1);
			q_cnt_q <= q_cnt_q + QCW'(ctl.q_push) - QCW'(q_pop);
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == drs_pkg::B_IDLE) begin
				k_q <= '0;
			end else if (load) begin
				k_q <= k_q + drs_pkg::NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.q_push) q_mem_q[q_wp_q] <= ctl.q_idx;
		if (q_pop) cur_idx_q <= q_mem_q[q_rp_q];
		case (state_q)
			drs_pkg::B_IDLE: begin
				if (ctl.start) begin
					bp_q   <= batch;
					head_q <= batch.head_init;
					clk_q  <= 56'd0;
					dsum_q <= 38'd0;
				end
			end
			drs_pkg::B_DIST: begin
				e_addr_q <= rb_rdata[95:64];
				e_cnt_q  <= rb_rdata[63:48];
				e_cyl_q  <= rb_rdata[47:16];
				e_sec_q  <= rb_rdata[15:0];
				dist_q   <= (rb_rdata[47:16] >= head_q) ? rb_rdata[47:16] - head_q
				                                        : head_q - rb_rdata[47:16];
			end
			drs_pkg::B_MUL: begin
				seek_q <= dist_q * bp_q.seek_ticks;
				tgt_q  <= e_sec_q * bp_q.rot_ticks;
				xfer_q <= e_cnt_q * bp_q.xfer_ticks;
			end
			drs_pkg::B_SEEK: begin
				clk_q  <= clk_seek;
				dsum_q <= dsum_q + 38'(dist_q);
				head_q <= e_cyl_q;
				rot_q  <= 32'd0;
			end
			drs_pkg::B_DIV: begin
				if (div_done) rot_q <= rot_calc;
			end
			drs_pkg::B_ROT: begin
				clk_q <= clk_q + 56'(rot_q) + 56'(xfer_q);
			end
			default: ;
		endcase
		if (load) begin
			arrival_index       <= 6'(cur_idx_q);
			served_address      <= e_addr_q;
			cylinder            <= e_cyl_q;
			sector              <= e_sec_q;
			seek_time           <= seek_q;
			rotation_wait       <= rot_q;
			transfer_time       <= xfer_q;
			done_time           <= clk_q;
			seek_distance_total <= dsum_q;
			overflow            <= bp_q.dropped;
			last_result         <= last;
		end
	end

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= QCW'(drs_pkg::QDEPTH))
		else $error("index queue count beyond depth");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == drs_pkg::B_IDLE)
		else $error("batch start while serving");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last) |=> (state_q == drs_pkg::B_IDLE && out_valid_q))
		else $error("back end not idle after last request");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.q_push |-> !q_full)
		else $error("push into full index queue");
`endif

endmodule

@@ rtl/core/disk_request_scheduler_cost.sv @@
// ----------------------------------------------------------------------------
// disk_request_scheduler_cost
// Batch disk request scheduler with seek, rotation and transfer timing.
// ----------------------------------------------------------------------------
// Requests enter through push/full and are stored until one carries
// batch_end. The front end then divides every address by sectors per track
// and orders the batch: fifo needs no scan, the other policies scan the whole
// batch once per pick. Picked indexes go through a four entry queue to the
// back end, which finds each rotation wait with its 56 bit modulo unit and
// places one result on the result ports while empty is low; pop takes it. A
// stalled pop holds the result and the back end waits; the front keeps
// ordering until the queue fills. The next batch may be loaded while the back
// end still serves; its address split waits for the back end to go idle.
// Configuration is sampled on the batch_end request. Reset clears all control
// state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module disk_request_scheduler_cost #(
	parameter int unsigned MAX_REQUESTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] block_address,
	input  logic [15:0] sector_count,
	input  logic        batch_end,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  arrival_index,
	output logic [31:0] served_address,
	output logic [31:0] cylinder,
	output logic [15:0] sector,
	output logic [47:0] seek_time,
	output logic [31:0] rotation_wait,
	output logic [31:0] transfer_time,
	output logic [55:0] done_time,
	output logic [37:0] seek_distance_total,
	output logic        overflow,
	output logic        last_result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	drs_pkg::back_status_t bst;
	drs_pkg::batch_t       batch;
	drs_pkg::front_ctl_t   ctl;
	drs_pkg::entry_wr_t    ewr;

	drs_front #(.MAX_REQUESTS(MAX_REQUESTS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.block_address (block_address),
		.sector_count  (sector_count),
		.batch_end     (batch_end),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bst           (bst),
		.batch         (batch),
		.ctl           (ctl),
		.ewr           (ewr)
	);

	drs_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.batch               (batch),
		.ctl                 (ctl),
		.ewr                 (ewr),
		.bst                 (bst),
		.empty               (empty),
		.pop                 (pop),
		.arrival_index       (arrival_index),
		.served_address      (served_address),
		.cylinder            (cylinder),
		.sector              (sector),
		.seek_time           (seek_time),
		.rotation_wait       (rotation_wait),
		.transfer_time       (transfer_time),
		.done_time           (done_time),
		.seek_distance_total (seek_distance_total),
		.overflow            (overflow),
		.last_result         (last_result)
	);

endmodule
